@@ design/fbsl_pkg.sv @@
// ----------------------------------------------------------------------------
// fbsl_pkg
// Shared types and constants for the four-button short/long press detector.
// ----------------------------------------------------------------------------
package fbsl_pkg;

    localparam int TIMER_W = 16;
    localparam int COUNT_W = 4;
    localparam int KEY_W   = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_BOUNCE_TICKS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS   = 1'b1;

    localparam logic [TIMER_W-1:0] BOUNCE_TICKS_RST = 16'd50;
    localparam logic [COUNT_W-1:0] LONG_PRESS_RST   = 4'd5;

    // key codes: short 1..4, long 5..8 in the order setup, zero, manual, pedal
    localparam logic [KEY_W-1:0] KEY_NONE       = 4'd0;
    localparam logic [KEY_W-1:0] KEY_SHORT_SETUP = 4'd1;
    localparam logic [KEY_W-1:0] KEY_SHORT_ZERO  = 4'd2;
    localparam logic [KEY_W-1:0] KEY_SHORT_MANUAL = 4'd3;
    localparam logic [KEY_W-1:0] KEY_SHORT_PEDAL = 4'd4;
    localparam logic [KEY_W-1:0] KEY_LONG_SETUP  = 4'd5;
    localparam logic [KEY_W-1:0] KEY_LONG_ZERO   = 4'd6;
    localparam logic [KEY_W-1:0] KEY_LONG_MANUAL = 4'd7;
    localparam logic [KEY_W-1:0] KEY_LONG_PEDAL  = 4'd8;
    localparam logic [KEY_W-1:0] LONG_OFFSET     = 4'd4;

    // pin levels, active low
    typedef struct packed {
        logic pedal_level;
        logic manual_level;
        logic zero_level;
        logic setup_level;
    } levels_t;

    typedef struct packed {
        logic [TIMER_W-1:0] bounce_ticks;
        logic [COUNT_W-1:0] long_press_intervals;
    } cfg_t;

endpackage

@@ design/fbsl_in_stage.sv @@
// ----------------------------------------------------------------------------
// fbsl_in_stage
// Input register: captures one tick of pin levels per transaction.
// ----------------------------------------------------------------------------
module fbsl_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [3:0]      in_data,    // [0] setup, [1] zero, [2] manual, [3] pedal
    output logic            in_ready,
    input  logic            advance,
    output logic            stage_valid,
    output fbsl_pkg::levels_t stage_levels
);

    logic              valid_reg;
    fbsl_pkg::levels_t levels_reg;

    assign in_ready     = !valid_reg || advance;
    assign stage_valid  = valid_reg;
    assign stage_levels = levels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            levels_reg <= fbsl_pkg::levels_t'(in_data);
        end
    end

endmodule

@@ design/fbsl_press_fsm.sv @@
// ----------------------------------------------------------------------------
// fbsl_press_fsm
// Press state machine with interval timer; one step per tick.
// ----------------------------------------------------------------------------
module fbsl_press_fsm (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fbsl_pkg::cfg_t                  cfg,
    input  logic                            step,
    input  fbsl_pkg::levels_t               levels,
    output logic [fbsl_pkg::KEY_W-1:0]      key_event
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BOUNCE,
        PH_HOLD,
        PH_WAIT
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [fbsl_pkg::KEY_W-1:0]      held_key_reg, held_key_next;
    logic [fbsl_pkg::COUNT_W-1:0]    hold_count_reg, hold_count_next;
    logic [fbsl_pkg::TIMER_W-1:0]    timer_reg, timer_next;
    logic                            done_reg, done_next;

    logic [3:0]                      down;
    logic [fbsl_pkg::TIMER_W-1:0]    reload;
    logic [fbsl_pkg::TIMER_W-1:0]    timer_dec;
    logic                            done_dec;
    logic                            held_down;

    assign down = ~{levels.pedal_level, levels.manual_level,
                    levels.zero_level, levels.setup_level};

    // a zero period behaves as one tick
    assign reload = (cfg.bounce_ticks == '0) ? fbsl_pkg::TIMER_W'(1) : cfg.bounce_ticks;

    assign timer_dec = (timer_reg != '0) ? timer_reg - fbsl_pkg::TIMER_W'(1) : timer_reg;
    assign done_dec  = done_reg || (timer_reg == fbsl_pkg::TIMER_W'(1));

    always_comb
    begin
        case (held_key_reg)
            fbsl_pkg::KEY_SHORT_SETUP,  fbsl_pkg::KEY_LONG_SETUP:  held_down = down[0];
            fbsl_pkg::KEY_SHORT_ZERO,   fbsl_pkg::KEY_LONG_ZERO:   held_down = down[1];
            fbsl_pkg::KEY_SHORT_MANUAL, fbsl_pkg::KEY_LONG_MANUAL: held_down = down[2];
            fbsl_pkg::KEY_SHORT_PEDAL,  fbsl_pkg::KEY_LONG_PEDAL:  held_down = down[3];
            default:                                               held_down = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        held_key_next   = held_key_reg;
        hold_count_next = hold_count_reg;
        timer_next      = timer_dec;
        done_next       = done_dec;
        key_event       = fbsl_pkg::KEY_NONE;

        case (phase_reg)
            PH_IDLE:
            begin
                if (down != 4'b0000)
                begin
                    // latch the highest-priority button
                    if (down[0])
                        held_key_next = fbsl_pkg::KEY_SHORT_SETUP;
                    else if (down[1])
                        held_key_next = fbsl_pkg::KEY_SHORT_ZERO;
                    else if (down[2])
                        held_key_next = fbsl_pkg::KEY_SHORT_MANUAL;
                    else
                        held_key_next = fbsl_pkg::KEY_SHORT_PEDAL;
                    timer_next = reload;
                    done_next  = 1'b0;
                    phase_next = PH_BOUNCE;
                end
            end
            PH_BOUNCE:
            begin
                if (done_dec)
                begin
                    if (!held_down)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        timer_next      = reload;
                        done_next       = 1'b0;
                        phase_next      = PH_HOLD;
                        hold_count_next = '0;
                    end
                end
            end
            PH_HOLD:
            begin
                if (done_dec)
                begin
                    if (!held_down)
                    begin
                        phase_next = PH_IDLE;
                        key_event  = held_key_reg;
                    end
                    else if (hold_count_reg < cfg.long_press_intervals)
                    begin
                        hold_count_next = hold_count_reg + fbsl_pkg::COUNT_W'(1);
                        timer_next      = reload;
                        done_next       = 1'b0;
                    end
                    else
                    begin
                        if (held_key_reg >= fbsl_pkg::KEY_SHORT_SETUP &&
                            held_key_reg <= fbsl_pkg::KEY_SHORT_PEDAL)
                        begin
                            held_key_next = held_key_reg + fbsl_pkg::LONG_OFFSET;
                        end
                        phase_next = PH_WAIT;
                        timer_next = reload;
                        done_next  = 1'b0;
                        key_event  = held_key_next;
                    end
                end
            end
            PH_WAIT:
            begin
                if (done_dec)
                begin
                    if (!held_down)
                    begin
                        held_key_next = fbsl_pkg::KEY_NONE;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        timer_next = reload;
                        done_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            held_key_reg   <= fbsl_pkg::KEY_NONE;
            hold_count_reg <= '0;
            timer_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            held_key_reg   <= held_key_next;
            hold_count_reg <= hold_count_next;
            timer_reg      <= timer_next;
            done_reg       <= done_next;
        end
    end

endmodule

@@ design/four_button_short_long_press.sv @@
// ----------------------------------------------------------------------------
// four_button_short_long_press
// Debounced short/long press detector for four active-low buttons.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave transaction carries one tick of four pin levels (0 = pressed).
//   Each tick yields exactly one master transaction holding key_event:
//   0 none, 1..4 short press, 5..8 long press (setup, zero, manual, pedal).
//   Latency: a tick is captured in the input register, then moves to the
//   result register, which presents it on the master side.
//   Throughput: one tick per cycle while the receiver does not stall; the press
//   state machine and interval timer logic is combinational between the two registers.
//   If the receiver stalls, the result register holds, the input register
//   fills, and s_axis_tready drops until the master side moves again.
//   Configuration: cfg_we writes register cfg_addr (0 bounce_ticks,
//   1 long_press_intervals) at the clock edge; write only while idle.
//   Reset clears both registers' valid flags, returns the state machine to
//   idle and restores bounce_ticks = 50 and long_press_intervals = 5.
// ----------------------------------------------------------------------------
module four_button_short_long_press (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fbsl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [fbsl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [0] setup_level, [1] zero_level,
                                                             // [2] manual_level, [3] pedal_level
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata   // [3:0] key_event
);

    fbsl_pkg::cfg_t                  cfg_reg;
    logic                            out_valid_reg;
    logic [fbsl_pkg::KEY_W-1:0]      out_event_reg;

    logic                            advance;
    logic                            stage_valid;
    fbsl_pkg::levels_t               stage_levels;
    logic                            step;
    logic [fbsl_pkg::KEY_W-1:0]      key_event;

    assign advance = !out_valid_reg || m_axis_tready;
    assign step    = stage_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bounce_ticks         <= fbsl_pkg::BOUNCE_TICKS_RST;
            cfg_reg.long_press_intervals <= fbsl_pkg::LONG_PRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                fbsl_pkg::REG_BOUNCE_TICKS:
                    cfg_reg.bounce_ticks <= cfg_wdata[fbsl_pkg::TIMER_W-1:0];
                fbsl_pkg::REG_LONG_PRESS:
                    cfg_reg.long_press_intervals <= cfg_wdata[fbsl_pkg::COUNT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    fbsl_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_data      (s_axis_tdata[3:0]),
        .in_ready     (s_axis_tready),
        .advance      (advance),
        .stage_valid  (stage_valid),
        .stage_levels (stage_levels)
    );

    fbsl_press_fsm u_press_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .step      (step),
        .levels    (stage_levels),
        .key_event (key_event)
    );

    // result register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_event_reg <= key_event;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_event_reg};

endmodule

@@ design/fbsl_checker.sv @@
// ----------------------------------------------------------------------------
// fbsl_checker
// Port-level checks for the press detector, bound to the top level.
// ----------------------------------------------------------------------------
module fbsl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic out_xfer;
    logic last_event_reg;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // remember whether the previous output transaction carried an event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_event_reg <= 1'b0;
        end
        else if (out_xfer)
        begin
            last_event_reg <= (m_axis_tdata[3:0] != 4'd0);
        end
    end

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'd0 && m_axis_tdata[3:0] <= 4'd8))
        else $error("key_event out of range");

    a_no_back_to_back_events: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && last_event_reg) |-> (m_axis_tdata[3:0] == 4'd0))
        else $error("two consecutive key events");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled while output register empty");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");

endmodule

bind four_button_short_long_press fbsl_checker u_fbsl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_four_button_short_long_press.sv @@
// ----------------------------------------------------------------------------
// tb_four_button_short_long_press
// Self-checking bench for the four-button short/long press detector: drives
// ticks of pin levels with random gaps and stalls, predicts every key_event
// in a scoreboard, and checks each result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_four_button_short_long_press;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BOUNCE,
        PH_HOLD,
        PH_WAIT
    } press_phase_t;

    // Tracks the press state machine and holds the key events still owed.
    class press_scoreboard;
        logic [fbsl_pkg::TIMER_W-1:0] bounce_ticks;
        logic [fbsl_pkg::COUNT_W-1:0] long_intervals;
        press_phase_t                 phase;
        logic [fbsl_pkg::KEY_W-1:0]   held_key;
        logic [fbsl_pkg::COUNT_W-1:0] hold_count;
        logic [fbsl_pkg::TIMER_W-1:0] timer;
        bit                           expired;
        logic [fbsl_pkg::KEY_W-1:0]   key_expected[$];
        int unsigned                  errors;

        function new();
            bounce_ticks   = fbsl_pkg::BOUNCE_TICKS_RST;
            long_intervals = fbsl_pkg::LONG_PRESS_RST;
            phase          = PH_IDLE;
            held_key       = fbsl_pkg::KEY_NONE;
            hold_count     = '0;
            timer          = '0;
            expired        = 1'b0;
            errors         = 0;
        endfunction

        function void write_reg(logic [fbsl_pkg::CFG_ADDR_W-1:0] addr,
                                logic [fbsl_pkg::CFG_DATA_W-1:0] data);
            if (addr == fbsl_pkg::REG_BOUNCE_TICKS)
                bounce_ticks = data[fbsl_pkg::TIMER_W-1:0];
            else
                long_intervals = data[fbsl_pkg::COUNT_W-1:0];
        endfunction

        // a zero period behaves as one tick
        function logic [fbsl_pkg::TIMER_W-1:0] interval_len();
            return (bounce_ticks == '0) ? fbsl_pkg::TIMER_W'(1) : bounce_ticks;
        endfunction

        function void restart_interval();
            timer   = interval_len();
            expired = 1'b0;
        endfunction

        function bit key_is_down(logic [3:0] down, logic [fbsl_pkg::KEY_W-1:0] code);
            if (code >= fbsl_pkg::KEY_SHORT_SETUP && code <= fbsl_pkg::KEY_SHORT_PEDAL)
                return down[2'(code - fbsl_pkg::KEY_SHORT_SETUP)];
            if (code >= fbsl_pkg::KEY_LONG_SETUP && code <= fbsl_pkg::KEY_LONG_PEDAL)
                return down[2'(code - fbsl_pkg::KEY_LONG_SETUP)];
            return 1'b0;
        endfunction

        function void note_tick(fbsl_pkg::levels_t lv);
            logic [3:0]                 down;
            logic [fbsl_pkg::KEY_W-1:0] key_event;
            bit                         held_down;
            down = ~{lv.pedal_level, lv.manual_level, lv.zero_level, lv.setup_level};
            key_event = fbsl_pkg::KEY_NONE;

            // timer counts down before the key logic looks at it
            if (timer != 0) begin
                timer = timer - 1'b1;
                if (timer == 0)
                    expired = 1'b1;
            end
            held_down = key_is_down(down, held_key);

            case (phase)
                PH_IDLE:
                begin
                    if (down != 4'b0000) begin
                        if (down[0])
                            held_key = fbsl_pkg::KEY_SHORT_SETUP;
                        else if (down[1])
                            held_key = fbsl_pkg::KEY_SHORT_ZERO;
                        else if (down[2])
                            held_key = fbsl_pkg::KEY_SHORT_MANUAL;
                        else
                            held_key = fbsl_pkg::KEY_SHORT_PEDAL;
                        restart_interval();
                        phase = PH_BOUNCE;
                    end
                end
                PH_BOUNCE:
                begin
                    if (expired) begin
                        if (!held_down) begin
                            phase = PH_IDLE;
                        end else begin
                            restart_interval();
                            phase      = PH_HOLD;
                            hold_count = '0;
                        end
                    end
                end
                PH_HOLD:
                begin
                    if (expired) begin
                        if (!held_down) begin
                            phase     = PH_IDLE;
                            key_event = held_key;
                        end else if (hold_count < long_intervals) begin
                            hold_count = hold_count + 1'b1;
                            restart_interval();
                        end else begin
                            if (held_key >= fbsl_pkg::KEY_SHORT_SETUP &&
                                held_key <= fbsl_pkg::KEY_SHORT_PEDAL)
                                held_key = held_key + fbsl_pkg::LONG_OFFSET;
                            phase = PH_WAIT;
                            restart_interval();
                            key_event = held_key;
                        end
                    end
                end
                default:
                begin
                    if (expired) begin
                        if (!held_down) begin
                            held_key = fbsl_pkg::KEY_NONE;
                            phase    = PH_IDLE;
                        end else begin
                            restart_interval();
                        end
                    end
                end
            endcase
            key_expected.push_back(key_event);
        endfunction

        function void check_event(logic [fbsl_pkg::KEY_W-1:0] actual);
            logic [fbsl_pkg::KEY_W-1:0] want;
            if (key_expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("key_event %0d arrived with nothing pending", actual);
                return;
            end
            want = key_expected.pop_front();
            if (actual !== want) begin
                errors++;
                if (errors <= 10)
                    $display("key_event mismatch: expected %0d, got %0d", want, actual);
            end
        endfunction

        function int unsigned pending();
            return key_expected.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [fbsl_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [fbsl_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;   // [0] setup, [1] zero, [2] manual, [3] pedal
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [7:0]                      m_axis_tdata;   // [3:0] key_event

    press_scoreboard sb = new();

    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    bit long_stall_req  = 1'b0;

    four_button_short_long_press dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // result side: check each transaction, then draw the next stall
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_event(m_axis_tdata[fbsl_pkg::KEY_W-1:0]);
                if (long_stall_req) begin
                    stall_left     = 60;
                    long_stall_req = 1'b0;
                end else begin
                    stall_left = receiver_steady ? 0 : $urandom_range(0, 3);
                end
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_axis_tready <= (stall_left == 0);
        end
    end

    task automatic send_tick(fbsl_pkg::levels_t lv);
        int unsigned gap;
        gap = sender_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, lv};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_tick(lv);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // hold the write until the clock edge takes it, then leave the port quiet
    task automatic write_reg(logic [fbsl_pkg::CFG_ADDR_W-1:0] addr,
                             logic [fbsl_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(addr, data);
        @(posedge clk);
    endtask

    // mostly press-hold-release runs of random length, some random noise
    task automatic press_runs(int unsigned count);
        int unsigned       sent, len, span;
        logic [3:0]        mask;
        fbsl_pkg::levels_t lv;
        span = 32'(sb.interval_len());
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    lv = fbsl_pkg::levels_t'(4'($urandom_range(0, 15)));
                    send_tick(lv);
                end
                sent += len;
            end else begin
                mask = 4'($urandom_range(1, 15));
                len  = $urandom_range(1, span * (sb.long_intervals + 3));
                repeat (len) send_tick(fbsl_pkg::levels_t'(~mask));
                sent += len;
                len = $urandom_range(1, 2 * span + 2);
                repeat (len) send_tick(fbsl_pkg::levels_t'(4'b1111));
                sent += len;
            end
        end
    endtask

    task automatic send_levels(logic [3:0] lv, int unsigned count);
        repeat (count) send_tick(fbsl_pkg::levels_t'(lv));
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= fbsl_pkg::REG_BOUNCE_TICKS;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'hFF;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset periods: a press that is released before debounce ends
        send_levels(4'b1110, 3);
        send_levels(4'b1111, 55);
        drain();

        write_reg(fbsl_pkg::REG_BOUNCE_TICKS, 16'd1);
        write_reg(fbsl_pkg::REG_LONG_PRESS, 16'd0);
        send_levels(4'b1110, 2);    // short setup
        send_levels(4'b1111, 1);
        send_levels(4'b1101, 3);    // long zero, then release
        send_levels(4'b1111, 2);
        send_levels(4'b0000, 2);    // all pressed, setup wins
        send_levels(4'b1111, 1);
        send_levels(4'b1011, 1);    // release during debounce
        send_levels(4'b1111, 1);
        send_levels(4'b0111, 1);    // long pedal, other buttons ignored
        send_levels(4'b0110, 1);
        send_levels(4'b0111, 1);
        send_levels(4'b1111, 1);
        send_levels(4'b1011, 2);    // short manual
        send_levels(4'b1111, 1);
        drain();

        // zero period acts as one; upper bits of the long-press interval count drop
        write_reg(fbsl_pkg::REG_BOUNCE_TICKS, 16'd0);
        write_reg(fbsl_pkg::REG_LONG_PRESS, 16'hFFF2);
        press_runs(150);
        drain();

        // back-to-back input with a long result stall
        write_reg(fbsl_pkg::REG_BOUNCE_TICKS, 16'd3);
        write_reg(fbsl_pkg::REG_LONG_PRESS, 16'd1);
        sender_steady = 1'b1;
        press_runs(40);
        long_stall_req = 1'b1;
        press_runs(110);
        sender_steady = 1'b0;
        drain();

        write_reg(fbsl_pkg::REG_BOUNCE_TICKS, 16'd2);
        write_reg(fbsl_pkg::REG_LONG_PRESS, 16'd15);
        press_runs(75);
        drain();
        press_runs(75);
        drain();

        write_reg(fbsl_pkg::REG_BOUNCE_TICKS, 16'd1);
        write_reg(fbsl_pkg::REG_LONG_PRESS, 16'd0);
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        press_runs(150);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        drain();

        write_reg(fbsl_pkg::REG_BOUNCE_TICKS, 16'd4);
        write_reg(fbsl_pkg::REG_LONG_PRESS, 16'd3);
        press_runs(150);
        drain();

        // widest settings: only the latch and start of debounce are reachable
        write_reg(fbsl_pkg::REG_BOUNCE_TICKS, 16'hFFFF);
        write_reg(fbsl_pkg::REG_LONG_PRESS, 16'd15);
        send_levels(4'b1111, 3);
        send_levels(4'b1011, 10);
        send_levels(4'b1111, 7);
        drain();

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[four_button_short_long_press] OK");
        else
            $display("[four_button_short_long_press] ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[four_button_short_long_press] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/fbsl_pkg.sv
design/fbsl_in_stage.sv
design/fbsl_press_fsm.sv
design/four_button_short_long_press.sv
design/fbsl_checker.sv
tb/tb_four_button_short_long_press.sv
